// ----- rtl/core/pbt_pkg.sv -----
// Shared types and constants for the PC breakpoint table.
package pbt_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int ADDR_W      = 16;
  localparam int SLOT_W      = 4;
  localparam int ENTRY_CNT_W = 5;
  localparam int LAST_W      = 17;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_CLEAR  = 3'd2,
    ACT_CHECK  = 3'd3,
    ACT_PAUSE  = 3'd4,
    ACT_RESUME = 3'd5,
    ACT_TAKE   = 3'd6,
    ACT_READ   = 3'd7
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [ADDR_W-1:0]   addr;
    logic [SLOT_W-1:0]   slot;
  } in_item_t;

  typedef struct packed {
    logic                   paused;
    logic                   hit;
    logic [ENTRY_CNT_W-1:0] entry_count;
    logic [LAST_W-1:0]      last_value;
    logic [ADDR_W-1:0]      entry_value;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ----- rtl/core/pbt_ctrl.sv -----
// Controller state machine for the PC breakpoint table.
module pbt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pbt_pkg::status_t status,
  output pbt_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        // The result can only be loaded once the output register is free.
        if (status.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/pbt_dpath.sv -----
// Datapath: breakpoint entries, compare vector, flags and the output register.
module pbt_dpath #(
  parameter int SLOTS = pbt_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pbt_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  pbt_pkg::cmd_t      cmd,
  output pbt_pkg::status_t   status,
  output logic               out_valid,
  input  logic               out_stall,
  output pbt_pkg::out_item_t out_data
);

  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int CNT_OUT_W = pbt_pkg::ENTRY_CNT_W;
  localparam int WIDE_W    = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam int ADDR_W    = pbt_pkg::ADDR_W;
  localparam int LAST_W    = pbt_pkg::LAST_W;

  logic [ADDR_W-1:0]  entries_r [SLOTS];
  logic [ADDR_W-1:0]  entries_nxt [SLOTS];
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               paused_r, paused_nxt;
  logic               skip_r, skip_nxt;
  logic [LAST_W-1:0]  last_hit_r, last_hit_nxt;
  logic               bp_enable_r;
  logic [SLOTS-1:0]   match_r, match_nxt;
  pbt_pkg::in_item_t  op_r;
  logic               out_valid_r;
  pbt_pkg::out_item_t out_data_r, out_data_nxt;

  logic [SLOTS-1:0]   from_first;
  logic               any_match;
  logic               found;
  logic [WIDE_W-1:0]  count_wide;
  logic [ADDR_W-1:0]  read_value;

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

  // Compare against every live entry as the transaction is taken.
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      match_nxt[j] = (entries_r[j] == in_data.addr) && (CNT_W'(j) < count_r);
    end
  end

  // Entries from the first match upward take part in a remove shift.
  always_comb begin
    found = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      found         = found | match_r[j];
      from_first[j] = found;
    end
  end

  assign any_match = |match_r;

  always_comb begin
    read_value = '0;
    for (int j = 0; j < SLOTS; j++) begin
      if ((int'(op_r.slot) == j) && (CNT_W'(j) < count_r)) begin
        read_value = entries_r[j];
      end
    end
  end

  always_comb begin
    entries_nxt  = entries_r;
    count_nxt    = count_r;
    paused_nxt   = paused_r;
    skip_nxt     = skip_r;
    last_hit_nxt = last_hit_r;
    out_data_nxt = '0;
    case (op_r.action)
      pbt_pkg::ACT_ADD: begin
        if (count_r < CNT_W'(SLOTS)) begin
          for (int j = 0; j < SLOTS; j++) begin
            if (CNT_W'(j) == count_r) begin
              entries_nxt[j] = op_r.addr;
            end
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end
      pbt_pkg::ACT_REMOVE: begin
        if (any_match) begin
          for (int j = 0; j + 1 < SLOTS; j++) begin
            if (from_first[j]) begin
              entries_nxt[j] = entries_r[j+1];
            end
          end
          count_nxt = count_r - CNT_W'(1);
        end
      end
      pbt_pkg::ACT_CLEAR: begin
        count_nxt = '0;
      end
      pbt_pkg::ACT_CHECK: begin
        if (!paused_r) begin
          if (bp_enable_r && !skip_r && any_match) begin
            paused_nxt       = 1'b1;
            last_hit_nxt     = {1'b0, op_r.addr} + LAST_W'(1);
            out_data_nxt.hit = 1'b1;
          end
          skip_nxt = 1'b0;
        end
      end
      pbt_pkg::ACT_PAUSE: begin
        paused_nxt = 1'b1;
      end
      pbt_pkg::ACT_RESUME: begin
        paused_nxt = 1'b0;
        skip_nxt   = 1'b1;
      end
      pbt_pkg::ACT_TAKE: begin
        out_data_nxt.last_value = last_hit_r;
        last_hit_nxt            = '0;
      end
      pbt_pkg::ACT_READ: begin
        out_data_nxt.entry_value = read_value;
      end
      default: begin
        out_data_nxt = '0;
      end
    endcase
    count_wide               = WIDE_W'(count_nxt);
    out_data_nxt.paused      = paused_nxt;
    out_data_nxt.entry_count = count_wide[CNT_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      paused_r    <= 1'b0;
      skip_r      <= 1'b0;
      last_hit_r  <= '0;
      bp_enable_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        bp_enable_r <= cfg_wdata;
      end
      if (cmd.exec) begin
        count_r     <= count_nxt;
        paused_r    <= paused_nxt;
        skip_r      <= skip_nxt;
        last_hit_r  <= last_hit_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_data;
      match_r <= match_nxt;
    end
    if (cmd.exec) begin
      entries_r  <= entries_nxt;
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- rtl/core/pc_breakpoint_table.sv -----
// Top level of the PC breakpoint table: controller plus datapath.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_stall    in_data  (action, addr, slot)
//   out_      output     out_valid / out_stall  out_data (paused, hit, entry_count,
//                                                         last_value, entry_value)
//   cfg_      input      cfg_we                 cfg_wdata (bp_enable)
//
// When a transaction is accepted, its address is compared against every entry in
// parallel and the match vector is registered; in the update state that follows, the
// first match is resolved and the table, flags and output register are updated.
// One transaction is in flight at a time. The result register frees the input side,
// but the update state waits while a previous result is still stalled.
// Reset is synchronous and empties the table, clears the flags and enables matching.
module pc_breakpoint_table #(
  parameter int SLOTS = pbt_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pbt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pbt_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  pbt_pkg::cmd_t    cmd;
  pbt_pkg::status_t status;

  pbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pbt_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the PC breakpoint table, with a scoreboard class and random traffic.
module tb_top;

  localparam int N_SLOTS        = pbt_pkg::SLOTS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;

  // Tracks the table contents and flags, and holds the responses still owed by the block.
  class bp_scoreboard;
    logic [pbt_pkg::ADDR_W-1:0] bp_addr [N_SLOTS];
    int                         bp_count;
    bit                         paused_flag;
    bit                         skip_flag;
    logic [pbt_pkg::LAST_W-1:0] last_hit;
    bit                         match_en;
    pbt_pkg::out_item_t         expected_resp [$];
    int                         errors;

    function new();
      for (int i = 0; i < N_SLOTS; i++) bp_addr[i] = '0;
      bp_count    = 0;
      paused_flag = 1'b0;
      skip_flag   = 1'b0;
      last_hit    = '0;
      match_en    = 1'b1;
      errors      = 0;
    endfunction

    function void set_enable(logic v);
      match_en = v;
    endfunction

    function int pending();
      return expected_resp.size();
    endfunction

    // Applies one accepted transaction to the tracked state and queues the response it owes.
    function void note_command(pbt_pkg::in_item_t cmd);
      pbt_pkg::out_item_t resp;
      int                 idx;
      resp = '0;
      case (cmd.action)
        pbt_pkg::ACT_ADD: begin
          if (bp_count < N_SLOTS) begin
            bp_addr[bp_count] = cmd.addr;
            bp_count++;
          end
        end
        pbt_pkg::ACT_REMOVE: begin
          idx = -1;
          for (int i = 0; i < bp_count; i++) begin
            if (idx < 0 && bp_addr[i] == cmd.addr) idx = i;
          end
          if (idx >= 0) begin
            for (int i = idx; i < bp_count - 1; i++) bp_addr[i] = bp_addr[i + 1];
            bp_count--;
          end
        end
        pbt_pkg::ACT_CLEAR: bp_count = 0;
        pbt_pkg::ACT_CHECK: begin
          // A paused unit makes no compare and keeps its skip flag.
          if (!paused_flag) begin
            if (match_en && !skip_flag) begin
              idx = -1;
              for (int i = 0; i < bp_count; i++) begin
                if (idx < 0 && bp_addr[i] == cmd.addr) idx = i;
              end
              if (idx >= 0) begin
                paused_flag = 1'b1;
                last_hit    = {1'b0, cmd.addr} + 17'd1;
                resp.hit    = 1'b1;
              end
            end
            skip_flag = 1'b0;
          end
        end
        pbt_pkg::ACT_PAUSE: paused_flag = 1'b1;
        pbt_pkg::ACT_RESUME: begin
          paused_flag = 1'b0;
          skip_flag   = 1'b1;
        end
        pbt_pkg::ACT_TAKE: begin
          resp.last_value = last_hit;
          last_hit        = '0;
        end
        default: begin
          if (int'(cmd.slot) < bp_count) resp.entry_value = bp_addr[cmd.slot];
        end
      endcase
      resp.paused      = paused_flag;
      resp.entry_count = pbt_pkg::ENTRY_CNT_W'(bp_count);
      expected_resp.push_back(resp);
    endfunction

    task report(string what);
      $display("ERROR at %0t: %s", $time, what);
      errors++;
    endtask

    task check_response(pbt_pkg::out_item_t got);
      pbt_pkg::out_item_t want;
      if (expected_resp.size() == 0) begin
        report("response with no outstanding transaction");
        return;
      end
      want = expected_resp.pop_front();
      if (got.paused !== want.paused)
        report($sformatf("paused got %0h expected %0h", got.paused, want.paused));
      if (got.hit !== want.hit)
        report($sformatf("hit got %0h expected %0h", got.hit, want.hit));
      if (got.entry_count !== want.entry_count)
        report($sformatf("entry_count got %0h expected %0h", got.entry_count,
                         want.entry_count));
      if (got.last_value !== want.last_value)
        report($sformatf("last_value got %0h expected %0h", got.last_value,
                         want.last_value));
      if (got.entry_value !== want.entry_value)
        report($sformatf("entry_value got %0h expected %0h", got.entry_value,
                         want.entry_value));
    endtask
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  pbt_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pbt_pkg::out_item_t out_data;
  logic               cfg_we    = 1'b0;
  logic               cfg_wdata = 1'b0;

  bp_scoreboard sb = new();

  bit tx_idle   = 1'b1;
  bit rx_idle   = 1'b1;
  bit hold_req  = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  pc_breakpoint_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: every handshake is sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_response(out_data);
      if (in_valid && !in_stall) sb.note_command(in_data);
      if (cfg_we) sb.set_enable(cfg_wdata);
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always begin
    @(negedge clk);
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall = 1'b1;
    end else begin
      out_stall = rx_idle && ($urandom_range(0, 99) < 15);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic pbt_pkg::in_item_t make_cmd(pbt_pkg::action_t act,
                                                 logic [pbt_pkg::ADDR_W-1:0] a,
                                                 logic [pbt_pkg::SLOT_W-1:0] s);
    pbt_pkg::in_item_t cmd;
    cmd.action = act;
    cmd.addr   = a;
    cmd.slot   = s;
    return cmd;
  endfunction

  // Offers one transaction and returns at the edge where it is accepted.
  task automatic send_cmd(pbt_pkg::in_item_t cmd);
    @(negedge clk);
    while (tx_idle && ($urandom_range(0, 99) < 15)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = cmd;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_enable(logic v);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Random transactions; most addresses come from a small pool so adds, removes and checks meet.
  task automatic run_random(int n);
    logic [pbt_pkg::ADDR_W-1:0] pool [6];
    logic [pbt_pkg::ADDR_W-1:0] a;
    pbt_pkg::action_t           act;
    int                         pick;
    pool[0] = '0;
    pool[1] = '1;
    for (int k = 2; k < 6; k++) pool[k] = pbt_pkg::ADDR_W'($urandom);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 20)      act = pbt_pkg::ACT_ADD;
      else if (pick < 30) act = pbt_pkg::ACT_REMOVE;
      else if (pick < 33) act = pbt_pkg::ACT_CLEAR;
      else if (pick < 63) act = pbt_pkg::ACT_CHECK;
      else if (pick < 68) act = pbt_pkg::ACT_PAUSE;
      else if (pick < 80) act = pbt_pkg::ACT_RESUME;
      else if (pick < 88) act = pbt_pkg::ACT_TAKE;
      else                act = pbt_pkg::ACT_READ;
      if ($urandom_range(0, 99) < 65) a = pool[$urandom_range(0, 5)];
      else a = pbt_pkg::ADDR_W'($urandom);
      send_cmd(make_cmd(act, a, pbt_pkg::SLOT_W'($urandom_range(0, 15))));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, duplicates, skip after resume, take-last, remove cases.
    send_cmd(make_cmd(pbt_pkg::ACT_ADD, 16'h0000, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_ADD, 16'hFFFF, 4'd15));
    send_cmd(make_cmd(pbt_pkg::ACT_ADD, 16'h1234, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_ADD, 16'h1234, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_READ, 16'h0000, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_READ, 16'hFFFF, 4'd3));
    send_cmd(make_cmd(pbt_pkg::ACT_READ, 16'h0000, 4'd15));
    send_cmd(make_cmd(pbt_pkg::ACT_CHECK, 16'h5555, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_CHECK, 16'hFFFF, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_CHECK, 16'h0000, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_TAKE, 16'h0000, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_TAKE, 16'hFFFF, 4'd15));
    send_cmd(make_cmd(pbt_pkg::ACT_RESUME, 16'h0000, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_CHECK, 16'h0000, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_CHECK, 16'h0000, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_RESUME, 16'h0000, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_RESUME, 16'h0000, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_PAUSE, 16'h0000, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_RESUME, 16'h0000, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_CHECK, 16'h1234, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_REMOVE, 16'h1234, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_REMOVE, 16'h9999, 4'd0));
    send_cmd(make_cmd(pbt_pkg::ACT_READ, 16'h0000, 4'd2));
    send_cmd(make_cmd(pbt_pkg::ACT_CLEAR, 16'hFFFF, 4'd15));
    send_cmd(make_cmd(pbt_pkg::ACT_READ, 16'h0000, 4'd0));

    run_random(150);

    write_enable(1'b0);
    run_random(100);
    write_enable(1'b1);

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_random(150);
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    // The receiver holds off while transactions keep coming, so the input side backs up.
    hold_req = 1'b1;
    run_random(100);

    drain();
    run_random(150);

    write_enable(1'b0);
    run_random(50);
    write_enable(1'b1);
    run_random(100);

    drain();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/pbt_pkg.sv
rtl/core/pbt_ctrl.sv
rtl/core/pbt_dpath.sv
rtl/core/pc_breakpoint_table.sv
bench/tb_top.sv
